// File: rtl/smm_pkg.sv
package smm_pkg;

	localparam int SPEAKERS    = 8;
	localparam int SAMPLE_BITS = 24;
	localparam int GAIN_BITS   = 16;

	localparam int GAIN_FRAC      = GAIN_BITS - 2;
	localparam int SLOT_W         = 16;
	localparam int SLOT_BITS      = (GAIN_BITS < SLOT_W) ? GAIN_BITS : SLOT_W;
	localparam int SLOTS_PER_WORD = 4;
	localparam int NUM_WORDS      = 4;
	localparam int NUM_SLOTS      = NUM_WORDS * SLOTS_PER_WORD;
	localparam int SLOT_IDX_W     = $clog2(NUM_SLOTS);
	localparam int WORD_W         = SLOT_W * SLOTS_PER_WORD;
	localparam int LEN_BITS       = 16;
	localparam int SPK_FIELD_W    = 4;
	localparam int SPK_W          = $clog2(SPEAKERS);
	localparam int CFG_INDEX_W    = 3;

	localparam logic [WORD_W-1:0] GAIN_WORD0_RESET = 64'h4000_0000_0000_4000;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_WORD_0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_WORD_3 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SLEW_LENGTH = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic signed [SAMPLE_BITS-1:0] accumulator_in;
		logic [SPK_FIELD_W-1:0]        speaker;
		logic                          frame_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mixed_out;
		logic                          clipped;
	} out_item_t;

endpackage

// File: rtl/stereo_mix_matrix_with_slew.sv
// Stereo to speaker mixing matrix with a linear gain ramp. Each request carries a left and a
// right sample, an existing output value and a speaker index; the block returns
// accumulator_in + left*gainL + right*gainR (sum of products rounded to the sample grid, halves up),
// saturated, with a clip flag. Speaker indexes beyond the speaker count give no result but
// still advance the ramp on frame_end. All arithmetic goes through one shared multiplier and
// one restoring divider under a sequencer: while a ramp runs, each gain first takes two
// multiplies, one load and 16 divider steps, then both samples are multiplied, summed and
// rounded. A new request is taken once the previous one has left for the output
// register, which holds the result until downstream takes it. Writing a gain word copies its
// previous gains into the old-gain store and restarts the ramp.
module stereo_mix_matrix_with_slew (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  smm_pkg::in_item_t                      in_item,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output smm_pkg::out_item_t                     out_item,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [smm_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [smm_pkg::WORD_W-1:0]             cfg_data
);
	import smm_pkg::*;

	localparam int MULB_W = LEN_BITS + 2;
	localparam int PROD_W = SAMPLE_BITS + MULB_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int NP_W   = SLOT_BITS + LEN_BITS + 1;
	localparam int REM_W  = LEN_BITS + 1;
	localparam int CNT_W  = $clog2(SLOT_BITS);
	localparam int MIX_W  = ACC_W - GAIN_FRAC;
	localparam int TOT_W  = MIX_W + 1;

	localparam logic signed [TOT_W-1:0] TOT_HI =
		TOT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [TOT_W-1:0] TOT_LO = -TOT_HI - TOT_W'(1);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_MUL_NEW = 9'b000000010,
		ST_MUL_OLD = 9'b000000100,
		ST_LOAD    = 9'b000001000,
		ST_DIV     = 9'b000010000,
		ST_MIX_L   = 9'b000100000,
		ST_MIX_R   = 9'b001000000,
		ST_SUM     = 9'b010000000,
		ST_OUT     = 9'b100000000
	} state_t;

	typedef logic [SLOTS_PER_WORD-1:0][SLOT_W-1:0] gain_word_t;

	state_t                          state_q;
	gain_word_t [NUM_WORDS-1:0]      gain_word_q;
	logic [NUM_SLOTS-1:0][SLOT_W-1:0] old_q;
	logic [LEN_BITS-1:0]             len_q;
	logic [LEN_BITS-1:0]             pos_q;
	in_item_t                        item_q;
	logic [SPK_W-1:0]                spk_q;
	logic                            side_q;
	logic signed [SLOT_BITS-1:0]     cur_gain_q [2];
	logic signed [PROD_W-1:0]        prod_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic [REM_W-1:0]                rem_q;
	logic [SLOT_BITS-1:0]            quo_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            out_valid_q;
	out_item_t                       out_item_q;

	logic                            ramp_on;
	logic                            accept;
	logic                            known;
	logic [SLOT_IDX_W-1:0]           idx;
	logic signed [SLOT_BITS-1:0]     g_new;
	logic signed [SLOT_BITS-1:0]     g_old;
	logic signed [SAMPLE_BITS-1:0]   mul_a;
	logic signed [MULB_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]        prod;
	logic signed [ACC_W-1:0]         nsum;
	logic [NP_W-1:0]                 np;
	logic [REM_W:0]                  trial;
	logic [REM_W:0]                  divisor;
	logic                            ge;
	logic [REM_W:0]                  trial_sub;
	logic signed [MIX_W-1:0]         mix;
	logic signed [TOT_W-1:0]         total;
	out_item_t                       result;
	logic                            out_free;
	logic                            load_out;

	function automatic logic signed [SLOT_BITS-1:0] new_gain(input logic [SLOT_IDX_W-1:0] i);
		return signed'(gain_word_q[i[SLOT_IDX_W-1:2]][i[1:0]][SLOT_BITS-1:0]);
	endfunction

	assign ramp_on   = (len_q != '0) && (pos_q < len_q);
	assign accept    = in_valid && !in_stall;
	assign known     = in_item.speaker < SPK_FIELD_W'(SPEAKERS);
	assign in_stall  = (state_q != ST_IDLE);
	// A write waits while a request is offered, so the two never land on the same edge.
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (state_q == ST_OUT) && out_free;

	assign idx   = SLOT_IDX_W'({spk_q, side_q});
	assign g_new = new_gain(idx);
	assign g_old = signed'(old_q[idx][SLOT_BITS-1:0]);

	always_comb begin
		unique case (state_q)
			ST_MUL_NEW: begin
				mul_a = SAMPLE_BITS'(g_new);
				mul_b = signed'(MULB_W'(pos_q));
			end
			ST_MUL_OLD: begin
				mul_a = SAMPLE_BITS'(g_old);
				mul_b = signed'(MULB_W'(len_q - pos_q));
			end
			ST_MIX_L: begin
				mul_a = item_q.left_sample;
				mul_b = MULB_W'(cur_gain_q[0]);
			end
			ST_MIX_R: begin
				mul_a = item_q.right_sample;
				mul_b = MULB_W'(cur_gain_q[1]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Shift the interpolation numerator up by half the quotient range times the divisor so
	// that an unsigned long division gives the signed quotient rounded to nearest, halves up.
	assign nsum = acc_q + ACC_W'(prod_q);
	assign np   = NP_W'({nsum, 1'b0}) + NP_W'(len_q) + (NP_W'(len_q) << SLOT_BITS);

	assign trial     = {rem_q, quo_q[SLOT_BITS-1]};
	assign divisor   = (REM_W + 1)'({len_q, 1'b0});
	assign ge        = trial >= divisor;
	assign trial_sub = trial - divisor;

	always_comb begin
		mix   = MIX_W'(acc_q >>> GAIN_FRAC);
		total = TOT_W'(item_q.accumulator_in) + TOT_W'(mix);
		priority if (total > TOT_HI) begin
			result.mixed_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			result.clipped   = 1'b1;
		end else if (total < TOT_LO) begin
			result.mixed_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			result.clipped   = 1'b1;
		end else begin
			result.mixed_out = total[SAMPLE_BITS-1:0];
			result.clipped   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_word_q <= (NUM_WORDS * WORD_W)'(GAIN_WORD0_RESET);
			old_q       <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			side_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= in_item;
						spk_q  <= in_item.speaker[SPK_W-1:0];
						side_q <= 1'b0;
						cur_gain_q[0] <= new_gain(SLOT_IDX_W'({in_item.speaker[SPK_W-1:0], 1'b0}));
						cur_gain_q[1] <= new_gain(SLOT_IDX_W'({in_item.speaker[SPK_W-1:0], 1'b1}));
						if (!known) begin
							if (in_item.frame_end && ramp_on) begin
								pos_q <= pos_q + LEN_BITS'(1);
							end
						end else if (ramp_on) begin
							state_q <= ST_MUL_NEW;
						end else begin
							state_q <= ST_MIX_L;
						end
					end
				end
				ST_MUL_NEW: begin
					prod_q  <= prod;
					state_q <= ST_MUL_OLD;
				end
				ST_MUL_OLD: begin
					acc_q   <= ACC_W'(prod_q);
					prod_q  <= prod;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rem_q   <= np[NP_W-1:SLOT_BITS];
					quo_q   <= np[SLOT_BITS-1:0];
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
					quo_q <= {quo_q[SLOT_BITS-2:0], ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SLOT_BITS - 1)) begin
						// Flipping the top bit removes the offset added before the division.
						cur_gain_q[side_q] <= signed'({quo_q[SLOT_BITS-2:0], ge}
							^ {1'b1, {(SLOT_BITS-1){1'b0}}});
						if (!side_q) begin
							side_q  <= 1'b1;
							state_q <= ST_MUL_NEW;
						end else begin
							state_q <= ST_MIX_L;
						end
					end
				end
				ST_MIX_L: begin
					prod_q  <= prod;
					state_q <= ST_MIX_R;
				end
				ST_MIX_R: begin
					acc_q   <= ACC_W'(prod_q);
					prod_q  <= prod;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					acc_q   <= nsum + ACC_W'(1 << (GAIN_FRAC - 1));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_item_q <= result;
						if (item_q.frame_end && ramp_on) begin
							pos_q <= pos_q + LEN_BITS'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= REG_GAIN_WORD_3) begin
					for (int s = 0; s < SLOTS_PER_WORD; s++) begin
						old_q[SLOT_IDX_W'({cfg_index[1:0], 2'(s)})] <= gain_word_q[cfg_index[1:0]][s];
					end
					gain_word_q[cfg_index[1:0]] <= cfg_data;
					pos_q <= '0;
				end else if (cfg_index == REG_SLEW_LENGTH) begin
					len_q <= cfg_data[LEN_BITS-1:0];
				end
			end
		end
	end

endmodule
